[sv/y2r_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package y2r_pkg;

  // BT.601 studio-range coefficients in Q10
  localparam int unsigned FracBits = 10;

  localparam logic signed [11:0] CoefLuma = 12'sd1192;
  localparam logic signed [12:0] CoefBCb  = 13'sd2066;
  localparam logic signed [11:0] CoefGCr  = 12'sd833;
  localparam logic signed [11:0] CoefGCb  = 12'sd403;
  localparam logic signed [11:0] CoefRCr  = 12'sd1634;

  localparam logic signed [8:0] LumaOff   = 9'sd16;
  localparam logic signed [8:0] ChromaOff = 9'sd128;

  localparam logic [7:0] ChanMax = 8'd255;

  // Accumulator: luma term plus one chroma term, worst case about +/-500k
  localparam int unsigned AccW = 22;

  typedef logic signed [19:0]     luma_term_t;
  typedef logic signed [AccW-1:0] acc_t;

  // Chroma contributions shared by both lanes of a macropixel
  typedef struct packed {
    logic signed [18:0] r_term;  // 1634*(Cr-128)
    logic signed [18:0] g_term;  // 833*(Cr-128) + 403*(Cb-128)
    logic signed [19:0] b_term;  // 2066*(Cb-128)
  } chroma_terms_t;

  // Negative clamps to zero, then drop fraction and clamp to 255
  function automatic logic [7:0] sat_channel(input acc_t acc);
    logic [7:0] res;
    if (acc[AccW-1]) begin
      res = '0;
    end else if (acc[AccW-2:FracBits+8] != '0) begin
      res = ChanMax;
    end else begin
      res = acc[FracBits+7:FracBits];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/y2r_chroma.sv]
`timescale 1ns / 1ps
`default_nettype none

module y2r_chroma (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [7:0]             chroma_blue_i,
  input  wire logic [7:0]             chroma_red_i,
  output y2r_pkg::chroma_terms_t      terms_o
);
  import y2r_pkg::*;

  logic signed [8:0]  db;
  logic signed [8:0]  dr;
  logic signed [20:0] r_prod;
  logic signed [20:0] gr_prod;
  logic signed [20:0] gb_prod;
  logic signed [21:0] b_prod;
  logic signed [21:0] g_sum;
  chroma_terms_t      terms_d;
  chroma_terms_t      terms_q;

  always_comb begin
    db      = $signed({1'b0, chroma_blue_i}) - ChromaOff;
    dr      = $signed({1'b0, chroma_red_i}) - ChromaOff;
    r_prod  = dr * CoefRCr;
    gr_prod = dr * CoefGCr;
    gb_prod = db * CoefGCb;
    b_prod  = db * CoefBCb;
    g_sum   = 22'(gr_prod) + 22'(gb_prod);
    terms_d.r_term = r_prod[18:0];
    terms_d.g_term = g_sum[18:0];
    terms_d.b_term = b_prod[19:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      terms_q <= terms_d;
    end
  end

  assign terms_o = terms_q;

endmodule

`default_nettype wire

[sv/y2r_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module y2r_lane (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [7:0]             luma_i,
  input  y2r_pkg::chroma_terms_t      terms_i,
  output logic [7:0]                  red_o,
  output logic [7:0]                  green_o,
  output logic [7:0]                  blue_o
);
  import y2r_pkg::*;

  logic signed [8:0]  y_off;
  logic signed [20:0] l_prod;
  luma_term_t         luma_d;
  luma_term_t         luma_q;
  acc_t               r_acc;
  acc_t               g_acc;
  acc_t               b_acc;

  always_comb begin
    y_off  = $signed({1'b0, luma_i}) - LumaOff;
    l_prod = y_off * CoefLuma;
    luma_d = l_prod[19:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      luma_q <= luma_d;
    end
  end

  // second stage: add shared chroma terms and saturate
  always_comb begin
    r_acc   = AccW'(luma_q) + AccW'(terms_i.r_term);
    g_acc   = AccW'(luma_q) - AccW'(terms_i.g_term);
    b_acc   = AccW'(luma_q) + AccW'(terms_i.b_term);
    red_o   = sat_channel(r_acc);
    green_o = sat_channel(g_acc);
    blue_o  = sat_channel(b_acc);
  end

endmodule

`default_nettype wire

[sv/yuyv_to_rgb888_converter_top.sv]
// YUYV macropixel to two RGB888 pixels, BT.601 studio range, Q10 arithmetic.
// An input transaction is registered in the product stage, then goes through
// sum/saturate into the output register, where valid_o rises; a held output
// can keep it waiting in the product stage. Throughput: 1 macropixel per
// cycle while the output is not held; both pixel lanes run in parallel.
// Reset (rst_ni, async, active low) empties both pipeline stages; no state.
`timescale 1ns / 1ps
`default_nettype none

module yuyv_to_rgb888_converter_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,

  input  wire logic       valid_i,
  output logic            stall_o,
  input  wire logic [7:0] luma_first_i,
  input  wire logic [7:0] chroma_blue_i,
  input  wire logic [7:0] luma_second_i,
  input  wire logic [7:0] chroma_red_i,
  input  wire logic       end_of_frame_i,

  output logic            valid_o,
  input  wire logic       stall_i,
  output logic [7:0]      red_first_o,
  output logic [7:0]      green_first_o,
  output logic [7:0]      blue_first_o,
  output logic [7:0]      red_second_o,
  output logic [7:0]      green_second_o,
  output logic [7:0]      blue_second_o,
  output logic            end_of_frame_out_o
);
  import y2r_pkg::*;

  // Pipeline control. Stage 1 holds the registered products, stage 2 is the
  // output register. Bubbles collapse: the input only stalls when both
  // stages are full and the output transaction is held off downstream.
  logic          s1_valid_q;
  logic          s1_valid_d;
  logic          out_valid_q;
  logic          out_valid_d;
  logic          s1_eof_q;
  logic          out_ld;      // stage 1 moves into the output register
  logic          s1_ld;       // input transaction captured into stage 1
  logic          out_free;

  chroma_terms_t terms;
  logic [7:0]    red0, green0, blue0;
  logic [7:0]    red1, green1, blue1;

  logic [7:0]    red0_q, green0_q, blue0_q;
  logic [7:0]    red1_q, green1_q, blue1_q;
  logic          eof_out_q;

  assign out_free = !out_valid_q || !stall_i;
  assign out_ld   = s1_valid_q && out_free;
  assign stall_o  = s1_valid_q && !out_free;
  assign s1_ld    = valid_i && !stall_o;

  always_comb begin
    s1_valid_d  = s1_ld || (s1_valid_q && !out_ld);
    out_valid_d = out_ld || (out_valid_q && stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Shared chroma products, one per macropixel
  y2r_chroma u_chroma (
    .clk_i         (clk_i),
    .en_i          (s1_ld),
    .chroma_blue_i (chroma_blue_i),
    .chroma_red_i  (chroma_red_i),
    .terms_o       (terms)
  );

  // Lane 0: first pixel of the pair
  y2r_lane u_lane0 (
    .clk_i   (clk_i),
    .en_i    (s1_ld),
    .luma_i  (luma_first_i),
    .terms_i (terms),
    .red_o   (red0),
    .green_o (green0),
    .blue_o  (blue0)
  );

  // Lane 1: second pixel of the pair
  y2r_lane u_lane1 (
    .clk_i   (clk_i),
    .en_i    (s1_ld),
    .luma_i  (luma_second_i),
    .terms_i (terms),
    .red_o   (red1),
    .green_o (green1),
    .blue_o  (blue1)
  );

  // Frame marker rides alongside the products
  always_ff @(posedge clk_i) begin
    if (s1_ld) begin
      s1_eof_q <= end_of_frame_i;
    end
  end

  // Merge both lanes into the output register
  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      red0_q    <= red0;
      green0_q  <= green0;
      blue0_q   <= blue0;
      red1_q    <= red1;
      green1_q  <= green1;
      blue1_q   <= blue1;
      eof_out_q <= s1_eof_q;
    end
  end

  assign valid_o            = out_valid_q;
  assign red_first_o        = red0_q;
  assign green_first_o      = green0_q;
  assign blue_first_o       = blue0_q;
  assign red_second_o       = red1_q;
  assign green_second_o     = green1_q;
  assign blue_second_o      = blue1_q;
  assign end_of_frame_out_o = eof_out_q;

  // An accepted transaction always lands in stage 1
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> s1_valid_q)
    else $error("accepted transaction did not reach stage 1");

  // A full stage 1 with a free output must produce a result next cycle
  a_s1_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !(out_valid_q && stall_i)) |=> out_valid_q)
    else $error("stage 1 failed to advance into output register");

  // A taken result with nothing behind it leaves the output empty
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !stall_i && !s1_valid_q) |=> !out_valid_q)
    else $error("result repeated after output transaction");

endmodule

`default_nettype wire

[test/yuyv_to_rgb888_pixel_checker.sv]
`timescale 1ns / 1ps

module yuyv_to_rgb888_pixel_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  // macropixel channel into the block
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] y0_i,
  input  logic [7:0] cb_i,
  input  logic [7:0] y1_i,
  input  logic [7:0] cr_i,
  input  logic       eof_i,
  // RGB pair channel out of the block
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] r0_i,
  input  logic [7:0] g0_i,
  input  logic [7:0] b0_i,
  input  logic [7:0] r1_i,
  input  logic [7:0] g1_i,
  input  logic [7:0] b1_i,
  input  logic       eof_out_i,
  output int         errors_o,
  output int         pending_o
);

  // BT.601 studio range, Q10
  localparam int KLuma      = 1192;
  localparam int KBlueCb    = 2066;
  localparam int KGreenCr   = 833;
  localparam int KGreenCb   = 403;
  localparam int KRedCr     = 1634;
  localparam int LumaBase   = 16;
  localparam int ChromaBase = 128;
  localparam int Frac       = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t first;
    rgb_t second;
    logic eof;
  } rgb_pair_t;

  rgb_pair_t expected_pairs[$];
  int        pair_count = 0;

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  function automatic logic [7:0] clamp_channel(input int acc);
    int whole;
    whole = acc >>> Frac;
    if (acc < 0) return 8'd0;
    if (whole > 255) return 8'hFF;
    return whole[7:0];
  endfunction

  function automatic rgb_t convert_pixel(input logic [7:0] y, input logic [7:0] cb,
                                         input logic [7:0] cr);
    int   lum;
    int   db;
    int   dr;
    rgb_t px;
    lum      = KLuma * (int'(y) - LumaBase);
    db       = int'(cb) - ChromaBase;
    dr       = int'(cr) - ChromaBase;
    px.red   = clamp_channel(lum + KRedCr * dr);
    px.green = clamp_channel(lum - KGreenCr * dr - KGreenCb * db);
    px.blue  = clamp_channel(lum + KBlueCb * db);
    return px;
  endfunction

  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors_o = errors_o + 1;
  endtask

  task automatic check_channel(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      report_error($sformatf("pair %0d %s got %0d want %0d", pair_count, name, got, want));
  endtask

  always @(posedge clk_i) begin
    rgb_pair_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        want.first  = convert_pixel(y0_i, cb_i, cr_i);
        want.second = convert_pixel(y1_i, cb_i, cr_i);
        want.eof    = eof_i;
        expected_pairs.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_pairs.size() == 0) begin
          report_error($sformatf("pair %0d arrived with nothing outstanding", pair_count));
        end else begin
          want = expected_pairs.pop_front();
          check_channel("red_first",    r0_i,      want.first.red);
          check_channel("green_first",  g0_i,      want.first.green);
          check_channel("blue_first",   b0_i,      want.first.blue);
          check_channel("red_second",   r1_i,      want.second.red);
          check_channel("green_second", g1_i,      want.second.green);
          check_channel("blue_second",  b1_i,      want.second.blue);
          check_channel("end_of_frame", 8'(eof_out_i), 8'(want.eof));
        end
        pair_count++;
      end
      pending_o = expected_pairs.size();
    end
  end

endmodule

[test/yuyv_to_rgb888_converter_top_tb.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the YUYV -> RGB888 converter. Prediction and
// comparison live in yuyv_to_rgb888_pixel_checker, which sits beside the DUT
// on the same wires and reports a mismatch count plus the number of
// transactions still in flight.
module yuyv_to_rgb888_converter_top_tb;

  localparam int ClkPeriod = 4;
  localparam int TimeoutNs = 2_000_000;  // far above the length of a slow run
  localparam int HoldCycles = 64;        // long output back-pressure burst

  // nominal luma range endpoints, used to bias random samples
  localparam int LumaBlack = 16;
  localparam int LumaWhite = 235;
  localparam int ChromaZero = 128;

  // Traffic shaping phases
  typedef enum logic [2:0] {
    PH_FREE,        // no gaps on either side
    PH_SEND_IDLE,   // sender drops valid 52% of cycles
    PH_RECV_STALL,  // receiver stalls 52% of cycles
    PH_BOTH,        // both at 29%
    PH_PRESSURE     // one long receiver hold while sender streams
  } phase_e;

  // Corner macropixels, packed {Y0, Cb, Y1, Cr}
  localparam logic [31:0] CornerPairs [22] = '{
    32'h00_00_00_00,  // everything at zero
    32'hFF_FF_FF_FF,  // everything at max
    32'h10_80_10_80,  // black, neutral chroma -> exact zero
    32'h0F_80_00_80,  // luma below black: negative sums
    32'hEB_80_EB_80,  // white: 254, just under the clamp
    32'hE8_80_EA_80,  // 251 and 253 must pass unclamped
    32'hEC_80_FF_80,  // first value past 255, and full luma
    32'h10_00_EB_00,  // chroma floor
    32'h10_FF_EB_FF,  // chroma ceiling
    32'h80_00_80_FF,
    32'h80_FF_80_00,
    32'h51_5A_29_F0,  // reference red bar
    32'h91_36_91_22,  // reference green bar
    32'h29_F0_29_6E,  // reference blue bar
    32'h10_10_EB_F0,
    32'hEB_F0_10_10,
    32'h7F_80_80_80,
    32'hAA_55_55_AA,  // alternating bit patterns
    32'h55_AA_AA_55,
    32'h01_02_FE_FD,
    32'hEB_81_EB_7F,  // near-neutral chroma around white
    32'hFF_00_00_FF
  };

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;

  // input side, driven on the falling edge
  logic       valid_i        = 1'b0;
  logic [7:0] luma_first_i   = '0;
  logic [7:0] chroma_blue_i  = '0;
  logic [7:0] luma_second_i  = '0;
  logic [7:0] chroma_red_i   = '0;
  logic       end_of_frame_i = 1'b0;
  logic       stall_o;

  // output side
  logic       stall_i = 1'b0;
  logic       valid_o;
  logic [7:0] red_first_o;
  logic [7:0] green_first_o;
  logic [7:0] blue_first_o;
  logic [7:0] red_second_o;
  logic [7:0] green_second_o;
  logic [7:0] blue_second_o;
  logic       end_of_frame_out_o;

  phase_e     phase = PH_FREE;
  int         errors;
  int         pending;

  // receiver hold-off bookkeeping
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  yuyv_to_rgb888_converter_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (valid_i),
    .stall_o            (stall_o),
    .luma_first_i       (luma_first_i),
    .chroma_blue_i      (chroma_blue_i),
    .luma_second_i      (luma_second_i),
    .chroma_red_i       (chroma_red_i),
    .end_of_frame_i     (end_of_frame_i),
    .valid_o            (valid_o),
    .stall_i            (stall_i),
    .red_first_o        (red_first_o),
    .green_first_o      (green_first_o),
    .blue_first_o       (blue_first_o),
    .red_second_o       (red_second_o),
    .green_second_o     (green_second_o),
    .blue_second_o      (blue_second_o),
    .end_of_frame_out_o (end_of_frame_out_o)
  );

  yuyv_to_rgb888_pixel_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_i),
    .in_stall_i  (stall_o),
    .y0_i        (luma_first_i),
    .cb_i        (chroma_blue_i),
    .y1_i        (luma_second_i),
    .cr_i        (chroma_red_i),
    .eof_i       (end_of_frame_i),
    .out_valid_i (valid_o),
    .out_stall_i (stall_i),
    .r0_i        (red_first_o),
    .g0_i        (green_first_o),
    .b0_i        (blue_first_o),
    .r1_i        (red_second_o),
    .g1_i        (green_second_o),
    .b1_i        (blue_second_o),
    .eof_out_i   (end_of_frame_out_o),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  function automatic int sender_idle_pct(input phase_e ph);
    case (ph)
      PH_SEND_IDLE: return 52;
      PH_BOTH:      return 29;
      default:      return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(input phase_e ph);
    case (ph)
      PH_RECV_STALL: return 52;
      PH_BOTH:       return 29;
      default:       return 0;
    endcase
  endfunction

  // Luma biased toward black and toward the 250..255 output clamp region
  function automatic logic [7:0] pick_luma();
    case ($urandom_range(9))
      0, 1:    return 8'(LumaBlack - 3 + $urandom_range(6));
      2, 3:    return 8'(LumaWhite - 4 + $urandom_range(8));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Chroma biased toward neutral and toward both rails
  function automatic logic [7:0] pick_chroma();
    case ($urandom_range(9))
      0, 1:    return 8'(ChromaZero - 6 + $urandom_range(12));
      2:       return 8'($urandom_range(5));
      3:       return 8'(250 + $urandom_range(5));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Receiver: random stall per phase, plus one long hold when the pressure
  // phase starts. The hold is counted here so the sender keeps offering and
  // the pipeline backs up into stall_o.
  always @(negedge clk_i) begin
    if (phase == PH_PRESSURE && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      stall_i <= 1'b1;
    end else begin
      stall_i <= ($urandom_range(99) < receiver_stall_pct(phase));
    end
  end

  // Offer one macropixel; entered and left at a falling edge. Valid is not
  // dropped after acceptance, so back-to-back transactions keep it high.
  task automatic send_pair(input logic [7:0] y0, input logic [7:0] cb,
                           input logic [7:0] y1, input logic [7:0] cr,
                           input logic eof, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      valid_i        <= 1'b0;
      // junk on the payload while idle
      luma_first_i   <= 8'($urandom);
      chroma_blue_i  <= 8'($urandom);
      luma_second_i  <= 8'($urandom);
      chroma_red_i   <= 8'($urandom);
      end_of_frame_i <= 1'($urandom);
      @(negedge clk_i);
    end
    valid_i        <= 1'b1;
    luma_first_i   <= y0;
    chroma_blue_i  <= cb;
    luma_second_i  <= y1;
    chroma_red_i   <= cr;
    end_of_frame_i <= eof;
    // stall_o read here is its pre-edge value: the transaction lands on the
    // first rising edge with stall low
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_phase(input phase_e ph, input int count);
    phase <= ph;
    repeat (count)
      send_pair(pick_luma(), pick_chroma(), pick_luma(), pick_chroma(),
                ($urandom_range(7) == 0), sender_idle_pct(ph));
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed corners, no gaps; end_of_frame toggled along the way
    for (int i = 0; i < 22; i++)
      send_pair(CornerPairs[i][31:24], CornerPairs[i][23:16], CornerPairs[i][15:8],
                CornerPairs[i][7:0], (i % 3 == 2) || (i == 21), 0);

    // random traffic, ~1500 transactions across the traffic phases
    run_phase(PH_FREE,       300);
    run_phase(PH_SEND_IDLE,  300);
    run_phase(PH_RECV_STALL, 300);
    run_phase(PH_BOTH,       300);
    run_phase(PH_PRESSURE,   300);
    valid_i <= 1'b0;

    // drain, then wait for any stray result to show up
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hard stop for a hung handshake
  initial begin
    #(TimeoutNs);
    $display("timeout with %0d transactions outstanding", pending);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
